>>> rtl/core/phbs_pkg.sv
// Shared types, codes and reset values for the proximity haptic and battery supervisor.
// No dependencies; every other file refers to this package by scoped names.
package phbs_pkg;

    localparam int READING_BITS_DEF = 10;
    localparam int THRESH_BITS      = 16;
    localparam int DIST_BITS        = 16;
    localparam int TIME_BITS        = 32;
    localparam int TICK_BITS        = 8;
    localparam int CFG_DATA_BITS    = 32;
    localparam int CFG_INDEX_BITS   = 3;
    localparam int OUT_TDATA_BITS   = 32;

    localparam logic [DIST_BITS-1:0]   ALERT_RANGE_RST      = 16'd1000;
    localparam int                     QUARTER_RST          = 850;
    localparam int                     HALF_RST             = 900;
    localparam int                     THREE_QUARTER_RST    = 950;
    localparam int                     FULL_RST             = 1000;
    localparam logic [TIME_BITS-1:0]   WARNING_PERIOD_RST   = 32'd300000;
    localparam logic [TICK_BITS-1:0]   CHECK_INTERVAL_RST   = 8'd20;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ALERT_RANGE      = 3'd0,
        CFG_QUARTER          = 3'd1,
        CFG_HALF             = 3'd2,
        CFG_THREE_QUARTER    = 3'd3,
        CFG_FULL             = 3'd4,
        CFG_WARNING_PERIOD   = 3'd5,
        CFG_CHECK_INTERVAL   = 3'd6
    } cfg_index_t;

    typedef enum logic [2:0] {
        LEVEL_EMPTY         = 3'd0,
        LEVEL_QUARTER       = 3'd1,
        LEVEL_HALF          = 3'd2,
        LEVEL_THREE_QUARTER = 3'd3,
        LEVEL_FULL          = 3'd4
    } level_t;

    typedef enum logic [2:0] {
        CHIRP_NONE          = 3'd0,
        CHIRP_SHUTDOWN      = 3'd1,
        CHIRP_LOW           = 3'd2,
        CHIRP_HALF          = 3'd3,
        CHIRP_THREE_QUARTER = 3'd4,
        CHIRP_FULL          = 3'd5
    } chirp_t;

    typedef struct packed {
        logic [DIST_BITS-1:0]   alert_range;
        logic [THRESH_BITS-1:0] quarter;
        logic [THRESH_BITS-1:0] half;
        logic [THRESH_BITS-1:0] three_quarter;
        logic [THRESH_BITS-1:0] full;
        logic [TIME_BITS-1:0]   warning_period;
        logic [TICK_BITS-1:0]   check_interval;
    } cfg_t;

    typedef struct packed {
        logic                 shutdown;
        chirp_t               chirp;
        level_t               level;
        logic                 checked;
        logic                 motor_on;
        logic [DIST_BITS-1:0] intensity;
    } result_t;

endpackage

>>> rtl/core/phbs_cfg_regs.sv
// Configuration register file of the supervisor, written through a plain write port.
// Depends on phbs_pkg for the register indexes, reset values and the cfg_t struct.
module phbs_cfg_regs #(
    parameter int READING_BITS = phbs_pkg::READING_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [phbs_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [phbs_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
    output phbs_pkg::cfg_t                        cfg
);

    localparam logic [phbs_pkg::THRESH_BITS-1:0] RD_MASK =
        phbs_pkg::THRESH_BITS'((32'd1 << READING_BITS) - 32'd1);

    phbs_pkg::cfg_t                        cfg_reg;
    logic [phbs_pkg::THRESH_BITS-1:0]      thresh_wdata;

    assign thresh_wdata = phbs_pkg::THRESH_BITS'(cfg_wdata[READING_BITS-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.alert_range      <= phbs_pkg::ALERT_RANGE_RST;
            cfg_reg.quarter          <= phbs_pkg::THRESH_BITS'(phbs_pkg::QUARTER_RST) & RD_MASK;
            cfg_reg.half             <= phbs_pkg::THRESH_BITS'(phbs_pkg::HALF_RST) & RD_MASK;
            cfg_reg.three_quarter    <=
                phbs_pkg::THRESH_BITS'(phbs_pkg::THREE_QUARTER_RST) & RD_MASK;
            cfg_reg.full             <= phbs_pkg::THRESH_BITS'(phbs_pkg::FULL_RST) & RD_MASK;
            cfg_reg.warning_period   <= phbs_pkg::WARNING_PERIOD_RST;
            cfg_reg.check_interval   <= phbs_pkg::CHECK_INTERVAL_RST;
        end else if (cfg_wr_en) begin
            unique case (phbs_pkg::cfg_index_t'(cfg_index))
                phbs_pkg::CFG_ALERT_RANGE: begin
                    cfg_reg.alert_range <= cfg_wdata[phbs_pkg::DIST_BITS-1:0];
                end
                phbs_pkg::CFG_QUARTER:       cfg_reg.quarter       <= thresh_wdata;
                phbs_pkg::CFG_HALF:          cfg_reg.half          <= thresh_wdata;
                phbs_pkg::CFG_THREE_QUARTER: cfg_reg.three_quarter <= thresh_wdata;
                phbs_pkg::CFG_FULL:          cfg_reg.full          <= thresh_wdata;
                phbs_pkg::CFG_WARNING_PERIOD: begin
                    cfg_reg.warning_period <= cfg_wdata[phbs_pkg::TIME_BITS-1:0];
                end
                phbs_pkg::CFG_CHECK_INTERVAL: begin
                    cfg_reg.check_interval <= cfg_wdata[phbs_pkg::TICK_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/phbs_tick_eval.sv
// Per-tick evaluation: motor intensity, battery classification, chirp selection and the
// supervisor state (tick counter, last level, last warning time, halt). Depends on phbs_pkg.
module phbs_tick_eval #(
    parameter int READING_BITS = phbs_pkg::READING_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              advance,
    input  phbs_pkg::cfg_t                    cfg,
    input  logic [phbs_pkg::DIST_BITS-1:0]    distance_mm,
    input  logic [READING_BITS-1:0]           battery_reading,
    input  logic                              button_pressed,
    input  logic [phbs_pkg::TIME_BITS-1:0]    now_ms,
    output phbs_pkg::result_t                 result
);

    logic [phbs_pkg::TICK_BITS-1:0]   tick_count_reg, tick_count_next;
    phbs_pkg::level_t                 last_level_reg, last_level_next;
    logic [phbs_pkg::TIME_BITS-1:0]   last_warning_ms_reg, last_warning_ms_next;
    logic                             halted_reg, halted_next;

    logic [phbs_pkg::DIST_BITS-1:0]   intensity;
    logic [phbs_pkg::THRESH_BITS-1:0] reading_ext;
    logic [phbs_pkg::TIME_BITS-1:0]   elapsed;
    logic                             check;
    phbs_pkg::level_t                 level;
    phbs_pkg::chirp_t                 entry_chirp;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg      <= '0;
            last_level_reg      <= phbs_pkg::LEVEL_FULL;
            last_warning_ms_reg <= '0;
            halted_reg          <= 1'b0;
        end else if (advance) begin
            tick_count_reg      <= tick_count_next;
            last_level_reg      <= last_level_next;
            last_warning_ms_reg <= last_warning_ms_next;
            halted_reg          <= halted_next;
        end
    end

    assign intensity   = (distance_mm < cfg.alert_range) ?
                         cfg.alert_range - distance_mm : '0;
    assign reading_ext = phbs_pkg::THRESH_BITS'(battery_reading);
    assign check       = (tick_count_reg == cfg.check_interval);
    assign elapsed     = now_ms - last_warning_ms_reg;

    always_comb begin
        priority if (reading_ext > cfg.full)          level = phbs_pkg::LEVEL_FULL;
        else if (reading_ext > cfg.three_quarter)     level = phbs_pkg::LEVEL_THREE_QUARTER;
        else if (reading_ext > cfg.half)              level = phbs_pkg::LEVEL_HALF;
        else if (reading_ext > cfg.quarter)           level = phbs_pkg::LEVEL_QUARTER;
        else                                          level = phbs_pkg::LEVEL_EMPTY;
    end

    always_comb begin
        unique case (level)
            phbs_pkg::LEVEL_HALF:          entry_chirp = phbs_pkg::CHIRP_HALF;
            phbs_pkg::LEVEL_THREE_QUARTER: entry_chirp = phbs_pkg::CHIRP_THREE_QUARTER;
            phbs_pkg::LEVEL_FULL:          entry_chirp = phbs_pkg::CHIRP_FULL;
            default:                       entry_chirp = phbs_pkg::CHIRP_NONE;
        endcase
    end

    always_comb begin
        tick_count_next      = tick_count_reg;
        last_level_next      = last_level_reg;
        last_warning_ms_next = last_warning_ms_reg;
        halted_next          = halted_reg;
        result               = '0;
        if (!halted_reg) begin
            result.intensity = intensity;
            result.motor_on  = (intensity != '0);
            if (check) begin
                result.checked  = 1'b1;
                result.level    = level;
                last_level_next = level;
                tick_count_next = '0;
                priority if (button_pressed || level == phbs_pkg::LEVEL_EMPTY) begin
                    result.chirp    = phbs_pkg::CHIRP_SHUTDOWN;
                    result.shutdown = 1'b1;
                    halted_next     = 1'b1;
                end else if (level == phbs_pkg::LEVEL_QUARTER) begin
                    // Entry chirps at once; a repeat needs elapsed > warning_period.
                    if (level != last_level_reg || elapsed > cfg.warning_period) begin
                        result.chirp         = phbs_pkg::CHIRP_LOW;
                        last_warning_ms_next = now_ms;
                    end
                end else if (level != last_level_reg) begin
                    result.chirp = entry_chirp;
                end
            end else begin
                tick_count_next = tick_count_reg + 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/proximity_haptic_battery_supervisor_core.sv
// Top level of the proximity haptic and battery supervisor: stream ports, input and result
// registers. Depends on phbs_pkg, phbs_cfg_regs and phbs_tick_eval.
//
//   Channel   Direction  Transfer          Contents
//   s_*       in         tvalid & tready   one sensor tick
//   m_*       out        tvalid & tready   one supervisor result per tick
//   cfg_*     in         cfg_wr_en         one register write
//
// Each tick passes through the input register and then through the evaluation logic into the
// result register. A new tick is accepted every cycle while the result stream is not stalled.
// aresetn is synchronous and clears the valid flags, the configuration and the supervisor state.
// A stalled result register holds its transaction; ticks keep entering while the input
// register is free or moves forward in the same cycle.
module proximity_haptic_battery_supervisor_core #(
    parameter int READING_BITS = phbs_pkg::READING_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // distance_mm, battery_reading, button_pressed, now_ms, zero fill.
    input  logic [((49 + READING_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // motor_intensity, motor_on, battery_checked, battery_level, chirp, shutdown, zero fill.
    output logic [phbs_pkg::OUT_TDATA_BITS-1:0]   m_tdata,
    input  logic                                  cfg_wr_en,
    input  logic [phbs_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [phbs_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

    localparam int READING_LSB = phbs_pkg::DIST_BITS;
    localparam int BUTTON_BIT  = READING_LSB + READING_BITS;
    localparam int NOW_LSB     = BUTTON_BIT + 1;
    localparam int RESULT_BITS = $bits(phbs_pkg::result_t);

    phbs_pkg::cfg_t                     cfg;
    phbs_pkg::result_t                  result;

    logic                               in_valid_reg;
    logic [phbs_pkg::DIST_BITS-1:0]     distance_reg;
    logic [READING_BITS-1:0]            reading_reg;
    logic                               button_reg;
    logic [phbs_pkg::TIME_BITS-1:0]     now_reg;

    logic                               out_valid_reg;
    phbs_pkg::result_t                  out_data_reg;

    logic                               out_ready;
    logic                               advance;

    assign out_ready = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            distance_reg <= s_tdata[phbs_pkg::DIST_BITS-1:0];
            reading_reg  <= s_tdata[READING_LSB +: READING_BITS];
            button_reg   <= s_tdata[BUTTON_BIT];
            now_reg      <= s_tdata[NOW_LSB +: phbs_pkg::TIME_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result;
        end
    end

    phbs_cfg_regs #(
        .READING_BITS (READING_BITS)
    ) u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    phbs_tick_eval #(
        .READING_BITS (READING_BITS)
    ) u_tick_eval (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .advance         (advance),
        .cfg             (cfg),
        .distance_mm     (distance_reg),
        .battery_reading (reading_reg),
        .button_pressed  (button_reg),
        .now_ms          (now_reg),
        .result          (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(phbs_pkg::OUT_TDATA_BITS - RESULT_BITS){1'b0}}, out_data_reg};

endmodule

>>> rtl/core/phbs_checker.sv
// Port-level checks on the result stream of the supervisor, bound to the top level.
// Depends on phbs_pkg for the chirp codes and the result layout.
module phbs_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [phbs_pkg::OUT_TDATA_BITS-1:0] m_tdata
);

    localparam int RESULT_BITS = $bits(phbs_pkg::result_t);

    phbs_pkg::result_t res;
    logic              shut_seen_reg;

    assign res = phbs_pkg::result_t'(m_tdata[RESULT_BITS-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shut_seen_reg <= 1'b0;
        end else if (m_tvalid && m_tready && res.shutdown) begin
            shut_seen_reg <= 1'b1;
        end
    end

    // Once a shutdown transaction has been delivered, every later transaction is all zero.
    a_halted_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && shut_seen_reg |-> m_tdata == '0)
        else $error("transaction after shutdown is not zero");

    a_motor_on: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> res.motor_on == (res.intensity != '0))
        else $error("motor enable disagrees with intensity");

    a_shutdown_chirp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.shutdown |-> res.checked && res.chirp == phbs_pkg::CHIRP_SHUTDOWN)
        else $error("shutdown without a battery check and shutdown chirp");

    a_chirp_needs_check: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !res.checked |-> res.chirp == phbs_pkg::CHIRP_NONE && res.level == '0)
        else $error("chirp or level reported on an unchecked tick");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result transaction changed");

endmodule

bind proximity_haptic_battery_supervisor_core phbs_checker u_phbs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
